// File: rtl/core/mpts_pkg.sv
// ----------------------------------------------------------------------------
// mpts_pkg
// Types, codes and field widths shared by the multi-policy task scheduler.
// ----------------------------------------------------------------------------
package mpts_pkg;

	// Request operation codes.
	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	// Scheduling policy codes.
	localparam logic [2:0] POL_FCFS  = 3'd0;
	localparam logic [2:0] POL_SJF   = 3'd1;
	localparam logic [2:0] POL_SRTF  = 3'd2;
	localparam logic [2:0] POL_PRIO  = 3'd3;
	localparam logic [2:0] POL_PPRIO = 3'd4;
	localparam logic [2:0] POL_RR    = 3'd5;

	// Configuration register indexes.
	localparam logic [1:0] REG_POLICY     = 2'd0;
	localparam logic [1:0] REG_QUANTUM    = 2'd1;
	localparam logic [1:0] REG_TASK_COUNT = 2'd2;

	localparam logic [3:0]  QUANTUM_RST    = 4'd4;
	localparam logic [4:0]  TASK_COUNT_RST = 5'd16;
	localparam logic [15:0] TIME_MAX       = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  slot;
		logic [11:0] arrival;
		logic [7:0]  burst;
		logic [7:0]  prio;
	} req_t;

	typedef struct packed {
		logic        running_valid;
		logic [3:0]  running_slot;
		logic [15:0] now_time;
		logic        finished;
		logic [15:0] waiting_time;
		logic [15:0] turnaround_time;
		logic        all_done;
	} rsp_t;

	// One row of the task table as read back by the sequencer.
	typedef struct packed {
		logic [11:0] arrival;
		logic [7:0]  burst;
		logic [7:0]  prio;
		logic [7:0]  remaining;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_SCAN,
		ST_DECIDE,
		ST_TURN,
		ST_WAIT,
		ST_OUT
	} state_t;

endpackage

// File: rtl/core/mpts_table.sv
// ----------------------------------------------------------------------------
// mpts_table
// Task table memories: arrival, burst, priority and remaining service time,
// one read port with registered data and one write port per array.
// ----------------------------------------------------------------------------
module mpts_table #(
	parameter int SLOTS = 16,
	parameter int IDX_W = $clog2(SLOTS)
) (
	input  logic                clk,
	input  logic                ld_en,
	input  logic [IDX_W-1:0]    ld_addr,
	input  logic [11:0]         ld_arrival,
	input  logic [7:0]          ld_burst,
	input  logic [7:0]          ld_prio,
	input  logic                rem_en,
	input  logic [IDX_W-1:0]    rem_addr,
	input  logic [7:0]          rem_data,
	input  logic [IDX_W-1:0]    rd_addr,
	output mpts_pkg::entry_t    rd_data
);

	logic [11:0] arr_mem [SLOTS];
	logic [7:0]  bur_mem [SLOTS];
	logic [7:0]  pri_mem [SLOTS];
	logic [7:0]  rem_mem [SLOTS];

	mpts_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (ld_en) begin
			arr_mem[ld_addr] <= ld_arrival;
			bur_mem[ld_addr] <= ld_burst;
			pri_mem[ld_addr] <= ld_prio;
		end
		if (rem_en) begin
			rem_mem[rem_addr] <= rem_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q.arrival   <= arr_mem[rd_addr];
		rd_data_q.burst     <= bur_mem[rd_addr];
		rd_data_q.prio      <= pri_mem[rd_addr];
		rd_data_q.remaining <= rem_mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/mpts_alu.sv
// ----------------------------------------------------------------------------
// mpts_alu
// Shared subtract and compare unit used for key compares during the slot
// scan and for the turnaround and waiting time differences.
// ----------------------------------------------------------------------------
module mpts_alu (
	input  logic [15:0] a,
	input  logic [15:0] b,
	output logic [15:0] diff,
	output logic        lt
);

	// The borrow out of the 17-bit difference is set exactly when a < b.
	assign {lt, diff} = {1'b0, a} - {1'b0, b};

endmodule

// File: rtl/core/mpts_ctrl.sv
// ----------------------------------------------------------------------------
// mpts_ctrl
// Scheduler sequencer: accepts requests, scans the task table one slot per
// cycle through the shared compare unit, updates the run state and holds the
// response register.
// ----------------------------------------------------------------------------
module mpts_ctrl #(
	parameter int SLOTS = 16,
	parameter int IDX_W = $clog2(SLOTS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  mpts_pkg::req_t      req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output mpts_pkg::rsp_t      rsp,
	input  logic [2:0]          policy,
	input  logic [3:0]          quantum,
	input  logic [4:0]          task_count,
	output logic                ld_en,
	output logic [IDX_W-1:0]    ld_addr,
	output logic [11:0]         ld_arrival,
	output logic [7:0]          ld_burst,
	output logic [7:0]          ld_prio,
	output logic                rem_en,
	output logic [IDX_W-1:0]    rem_addr,
	output logic [7:0]          rem_data,
	output logic [IDX_W-1:0]    rd_addr,
	input  mpts_pkg::entry_t    rd_data
);

	localparam int CNT_W = $clog2(SLOTS + 1);

	mpts_pkg::state_t state_q, state_d;

	// Run state.
	logic [15:0]      clock_q;
	logic [IDX_W-1:0] cur_slot_q;
	logic             cur_valid_q;
	logic [3:0]       slice_q;
	logic [SLOTS-1:0] done_q;
	logic [SLOTS-1:0] fresh_q;

	// Scan state.
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [11:0]      best_key_q;
	logic [11:0]      best_arr_q;
	logic [7:0]       best_bur_q;
	logic [7:0]       best_rem_q;
	logic             cur_elig_q;
	logic [11:0]      cur_arr_q;
	logic [7:0]       cur_bur_q;
	logic [7:0]       cur_rem_q;

	// Finish bookkeeping and response fields.
	logic [11:0]      sel_arr_q;
	logic [7:0]       sel_bur_q;
	logic [15:0]      turn_q;
	logic             res_run_q;
	logic [3:0]       res_slot_q;
	logic             res_fin_q;
	logic [15:0]      res_wait_q;
	logic [15:0]      res_turn_q;
	logic             rsp_valid_q;
	mpts_pkg::rsp_t   rsp_q;

	logic             accept;
	logic             slot_ok;
	logic [CNT_W-1:0] count;
	logic [2:0]       pol;
	logic [3:0]       qval;
	logic [15:0]      clk_inc;
	logic [CNT_W-1:0] start_idx;
	logic [CNT_W-1:0] idx_next;
	logic             mod_sub;
	logic             scan_issue;
	logic             scan_end;
	logic             rd_elig;
	logic             rd_is_cur;
	logic [7:0]       rem_eff;
	logic [11:0]      key;
	logic             is_max;
	logic             take;
	logic             nonpre;
	logic             keep;
	logic             have;
	logic [IDX_W-1:0] sel_idx;
	logic [11:0]      sel_arr;
	logic [7:0]       sel_bur;
	logic [7:0]       sel_rem;
	logic [7:0]       rem_new;
	logic [3:0]       slice_base;
	logic [3:0]       slice_dec;
	logic [SLOTS-1:0] use_mask;
	logic             all_done;
	logic             out_load;
	logic [15:0]      alu_a;
	logic [15:0]      alu_b;
	logic [15:0]      alu_diff;
	logic             alu_lt;
	logic [15:0]      alu_sat;

	mpts_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.lt   (alu_lt)
	);

	assign accept  = req_valid && req_ready;
	assign slot_ok = 32'(req.slot) < SLOTS;
	assign count   = (32'(task_count) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(task_count);
	assign pol     = (policy > mpts_pkg::POL_RR) ? mpts_pkg::POL_FCFS : policy;
	assign qval    = (quantum == 4'd0) ? 4'd1 : quantum;
	assign clk_inc = (clock_q == mpts_pkg::TIME_MAX) ? clock_q : clock_q + 16'd1;

	// Round robin starts after the current task, or at the stale slot when idle.
	assign start_idx = cur_valid_q ? CNT_W'(cur_slot_q) + CNT_W'(1) : CNT_W'(cur_slot_q);
	assign idx_next  = (idx_q + CNT_W'(1) == count) ? '0 : idx_q + CNT_W'(1);
	assign mod_sub   = (state_q == mpts_pkg::ST_MOD) && (count != '0) && (idx_q >= count);

	assign scan_issue = (state_q == mpts_pkg::ST_SCAN) && (cnt_q < count);
	assign scan_end   = (state_q == mpts_pkg::ST_SCAN) && !(cnt_q < count) && !vld_s1;

	// Data stage of the scan: the table row of slot idx_s1 is on rd_data.
	assign rd_elig   = vld_s1 && !done_q[idx_s1] && (16'(rd_data.arrival) <= clock_q);
	assign rd_is_cur = idx_s1 == cur_slot_q;
	assign rem_eff   = fresh_q[idx_s1] ? rd_data.burst : rd_data.remaining;
	assign is_max    = (pol == mpts_pkg::POL_PRIO) || (pol == mpts_pkg::POL_PPRIO);

	always_comb begin
		case (pol) inside
			mpts_pkg::POL_SJF:                     key = 12'(rd_data.burst);
			mpts_pkg::POL_SRTF:                    key = 12'(rem_eff);
			mpts_pkg::POL_PRIO, mpts_pkg::POL_PPRIO: key = 12'(rd_data.prio);
			default:                               key = rd_data.arrival;
		endcase
	end

	assign take = rd_elig && ((pol == mpts_pkg::POL_RR) ? !found_q : (!found_q || alu_lt));

	// Selection at the end of the scan.
	assign nonpre = (pol == mpts_pkg::POL_FCFS) || (pol == mpts_pkg::POL_SJF) ||
		(pol == mpts_pkg::POL_PRIO);
	assign keep = cur_valid_q && cur_elig_q &&
		(nonpre || ((pol == mpts_pkg::POL_RR) && (slice_q != 4'd0)));
	assign have    = keep || found_q;
	assign sel_idx = keep ? cur_slot_q : best_idx_q;
	assign sel_arr = keep ? cur_arr_q : best_arr_q;
	assign sel_bur = keep ? cur_bur_q : best_bur_q;
	assign sel_rem = keep ? cur_rem_q : best_rem_q;
	assign rem_new = (sel_rem != 8'd0) ? sel_rem - 8'd1 : 8'd0;
	assign slice_base = ((pol == mpts_pkg::POL_RR) && !keep) ? qval : slice_q;
	assign slice_dec  = ((pol == mpts_pkg::POL_RR) && (slice_base != 4'd0)) ?
		slice_base - 4'd1 : slice_base;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			use_mask[i] = i < 32'(count);
		end
	end
	assign all_done = &(done_q | ~use_mask);

	assign alu_sat  = alu_lt ? 16'd0 : alu_diff;
	assign out_load = (state_q == mpts_pkg::ST_OUT) && (!rsp_valid_q || rsp_ready);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpts_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.op == mpts_pkg::OP_TICK) begin
						state_d = (pol == mpts_pkg::POL_RR) ? mpts_pkg::ST_MOD : mpts_pkg::ST_SCAN;
					end else begin
						state_d = mpts_pkg::ST_OUT;
					end
				end
			end
			mpts_pkg::ST_MOD: begin
				if (!mod_sub) begin
					state_d = mpts_pkg::ST_SCAN;
				end
			end
			mpts_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = mpts_pkg::ST_DECIDE;
				end
			end
			mpts_pkg::ST_DECIDE: begin
				state_d = (have && (rem_new == 8'd0)) ? mpts_pkg::ST_TURN : mpts_pkg::ST_OUT;
			end
			mpts_pkg::ST_TURN: state_d = mpts_pkg::ST_WAIT;
			mpts_pkg::ST_WAIT: state_d = mpts_pkg::ST_OUT;
			mpts_pkg::ST_OUT: begin
				if (out_load) begin
					state_d = mpts_pkg::ST_IDLE;
				end
			end
			default: state_d = mpts_pkg::ST_IDLE;
		endcase
	end

	// Outputs: handshake, table ports and operands of the shared unit.
	always_comb begin
		req_ready  = state_q == mpts_pkg::ST_IDLE;
		ld_en      = accept && (req.op == mpts_pkg::OP_LOAD) && slot_ok;
		ld_addr    = IDX_W'(req.slot);
		ld_arrival = req.arrival;
		ld_burst   = req.burst;
		ld_prio    = req.prio;
		rem_en     = (state_q == mpts_pkg::ST_DECIDE) && have;
		rem_addr   = sel_idx;
		rem_data   = rem_new;
		rd_addr    = idx_q[IDX_W-1:0];
		alu_a      = '0;
		alu_b      = '0;
		unique case (state_q)
			mpts_pkg::ST_SCAN: begin
				if (is_max) begin
					alu_a = 16'(best_key_q);
					alu_b = 16'(key);
				end else begin
					alu_a = 16'(key);
					alu_b = 16'(best_key_q);
				end
			end
			mpts_pkg::ST_TURN: begin
				alu_a = clock_q;
				alu_b = 16'(sel_arr_q);
			end
			mpts_pkg::ST_WAIT: begin
				alu_a = turn_q;
				alu_b = 16'(sel_bur_q);
			end
			default: begin
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mpts_pkg::ST_IDLE;
			clock_q     <= '0;
			cur_slot_q  <= '0;
			cur_valid_q <= 1'b0;
			slice_q     <= '0;
			done_q      <= '0;
			fresh_q     <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
			cur_elig_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				mpts_pkg::ST_IDLE: begin
					if (accept) begin
						case (req.op)
							mpts_pkg::OP_LOAD: begin
								if (slot_ok) begin
									done_q[ld_addr]  <= 1'b0;
									fresh_q[ld_addr] <= 1'b1;
								end
							end
							mpts_pkg::OP_TICK: begin
								cnt_q      <= '0;
								vld_s1     <= 1'b0;
								found_q    <= 1'b0;
								cur_elig_q <= 1'b0;
								idx_q      <= (pol == mpts_pkg::POL_RR) ? start_idx : '0;
							end
							mpts_pkg::OP_RESTART: begin
								// Fresh slots read their remaining time as the burst.
								done_q      <= '0;
								fresh_q     <= '1;
								clock_q     <= '0;
								cur_slot_q  <= '0;
								cur_valid_q <= 1'b0;
								slice_q     <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				mpts_pkg::ST_MOD: begin
					if (mod_sub) begin
						idx_q <= idx_q - count;
					end
				end
				mpts_pkg::ST_SCAN: begin
					vld_s1 <= scan_issue;
					if (scan_issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
						idx_q <= idx_next;
					end
					if (take) begin
						found_q <= 1'b1;
					end
					if (rd_elig && rd_is_cur) begin
						cur_elig_q <= 1'b1;
					end
				end
				mpts_pkg::ST_DECIDE: begin
					clock_q <= clk_inc;
					if (!have) begin
						cur_valid_q <= 1'b0;
					end else begin
						cur_slot_q       <= sel_idx;
						fresh_q[sel_idx] <= 1'b0;
						if (rem_new == 8'd0) begin
							done_q[sel_idx] <= 1'b1;
							cur_valid_q     <= 1'b0;
							slice_q         <= '0;
						end else begin
							cur_valid_q <= 1'b1;
							slice_q     <= slice_dec;
						end
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_run_q  <= 1'b0;
			res_slot_q <= '0;
			res_fin_q  <= 1'b0;
			res_wait_q <= '0;
			res_turn_q <= '0;
		end
		if (scan_issue) begin
			idx_s1 <= idx_q[IDX_W-1:0];
		end
		if ((state_q == mpts_pkg::ST_SCAN) && take) begin
			best_idx_q <= idx_s1;
			best_key_q <= key;
			best_arr_q <= rd_data.arrival;
			best_bur_q <= rd_data.burst;
			best_rem_q <= rem_eff;
		end
		if ((state_q == mpts_pkg::ST_SCAN) && rd_elig && rd_is_cur) begin
			cur_arr_q <= rd_data.arrival;
			cur_bur_q <= rd_data.burst;
			cur_rem_q <= rem_eff;
		end
		if (state_q == mpts_pkg::ST_DECIDE) begin
			sel_arr_q <= sel_arr;
			sel_bur_q <= sel_bur;
			if (have) begin
				res_run_q  <= 1'b1;
				res_slot_q <= 4'(sel_idx);
				res_fin_q  <= rem_new == 8'd0;
			end
		end
		if (state_q == mpts_pkg::ST_TURN) begin
			turn_q     <= alu_sat;
			res_turn_q <= alu_sat;
		end
		if (state_q == mpts_pkg::ST_WAIT) begin
			res_wait_q <= alu_sat;
		end
		if (out_load) begin
			rsp_q.running_valid   <= res_run_q;
			rsp_q.running_slot    <= res_slot_q;
			rsp_q.now_time        <= clock_q;
			rsp_q.finished        <= res_fin_q;
			rsp_q.waiting_time    <= res_wait_q;
			rsp_q.turnaround_time <= res_turn_q;
			rsp_q.all_done        <= all_done;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/core/multi_policy_task_scheduler.sv
// ----------------------------------------------------------------------------
// multi_policy_task_scheduler
// Task table scheduler with first-come-first-served, shortest job first,
// shortest remaining time, priority, preemptive priority and round robin.
// ----------------------------------------------------------------------------
// A load or restart request goes from the idle state to the output state, where
// its response is registered. A tick request walks the slots in use through the
// single table read port and one shared compare unit, one slot per cycle; when
// the running task completes, its turnaround and waiting times are formed in
// the turn and wait states, and under round robin a modulo state first brings
// the start slot below task_count. A new request is accepted while the previous
// response still waits in the output register.
module multi_policy_task_scheduler #(
	parameter int SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  mpts_pkg::req_t      req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output mpts_pkg::rsp_t      rsp,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_addr,
	input  logic [4:0]          cfg_wdata
);

	localparam int IDX_W = $clog2(SLOTS);

	logic [2:0] policy_q;
	logic [3:0] quantum_q;
	logic [4:0] task_count_q;

	logic             ld_en;
	logic [IDX_W-1:0] ld_addr;
	logic [11:0]      ld_arrival;
	logic [7:0]       ld_burst;
	logic [7:0]       ld_prio;
	logic             rem_en;
	logic [IDX_W-1:0] rem_addr;
	logic [7:0]       rem_data;
	logic [IDX_W-1:0] rd_addr;
	mpts_pkg::entry_t rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q     <= mpts_pkg::POL_FCFS;
			quantum_q    <= mpts_pkg::QUANTUM_RST;
			task_count_q <= mpts_pkg::TASK_COUNT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				mpts_pkg::REG_POLICY:     policy_q     <= cfg_wdata[2:0];
				mpts_pkg::REG_QUANTUM:    quantum_q    <= cfg_wdata[3:0];
				mpts_pkg::REG_TASK_COUNT: task_count_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	mpts_table #(
		.SLOTS (SLOTS),
		.IDX_W (IDX_W)
	) u_table (
		.clk        (clk),
		.ld_en      (ld_en),
		.ld_addr    (ld_addr),
		.ld_arrival (ld_arrival),
		.ld_burst   (ld_burst),
		.ld_prio    (ld_prio),
		.rem_en     (rem_en),
		.rem_addr   (rem_addr),
		.rem_data   (rem_data),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	mpts_ctrl #(
		.SLOTS (SLOTS),
		.IDX_W (IDX_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.policy     (policy_q),
		.quantum    (quantum_q),
		.task_count (task_count_q),
		.ld_en      (ld_en),
		.ld_addr    (ld_addr),
		.ld_arrival (ld_arrival),
		.ld_burst   (ld_burst),
		.ld_prio    (ld_prio),
		.rem_en     (rem_en),
		.rem_addr   (rem_addr),
		.rem_data   (rem_data),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

endmodule

// File: test/multi_policy_task_scheduler_checker.sv
// ----------------------------------------------------------------------------
// multi_policy_task_scheduler_checker
// Watches the request, response and register ports of the task scheduler. It
// keeps its own copy of the task table and the scheduling state, works out the
// status that each accepted request must return, and compares every accepted
// response field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module multi_policy_task_scheduler_checker #(
	parameter int SLOTS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  mpts_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  mpts_pkg::rsp_t rsp,
	input  logic           cfg_wr_en,
	input  logic [1:0]     cfg_addr,
	input  logic [4:0]     cfg_wdata,
	output int             fail_count,
	output int             pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import mpts_pkg::*;

	logic [11:0] arrival_tbl [SLOTS];
	logic [7:0]  burst_tbl [SLOTS];
	logic [7:0]  prio_tbl [SLOTS];
	logic [7:0]  left_tbl [SLOTS];
	logic        done_tbl [SLOTS];
	logic [15:0] sched_time;
	logic [3:0]  run_slot;
	logic        run_valid;
	logic [3:0]  slice_cnt;

	logic [2:0]  policy_r;
	logic [3:0]  quantum_r;
	logic [4:0]  count_r;

	rsp_t awaited_status [$];
	rsp_t want;
	int   fails = 0;
	int   predicted = 0;
	int   retired = 0;

	assign fail_count = fails;
	assign pending = predicted - retired;

	function automatic int slots_in_use();
		return (count_r > SLOTS) ? SLOTS : int'(count_r);
	endfunction

	function automatic bit ready_to_run(int i, int n);
		return i < n && !done_tbl[i] && arrival_tbl[i] <= sched_time;
	endfunction

	function automatic void advance_time();
		if (sched_time != TIME_MAX)
			sched_time++;
	endfunction

	function automatic rsp_t run_one_tick();
		rsp_t        o;
		int          n;
		int          q;
		int          sel;
		int          start;
		int          idx;
		int          key;
		int          best;
		int          turn;
		int          wt;
		int          k;
		logic [2:0]  pol;
		bit          found;
		o = '0;
		n = slots_in_use();
		q = (quantum_r == 0) ? 1 : int'(quantum_r);
		pol = (policy_r > POL_RR) ? POL_FCFS : policy_r;
		sel = 0;
		found = 0;
		best = 0;
		if ((pol == POL_FCFS || pol == POL_SJF || pol == POL_PRIO) && run_valid &&
				ready_to_run(run_slot, n)) begin
			sel = run_slot;
			found = 1;
		end else if (pol == POL_RR && run_valid && slice_cnt != 0 &&
				ready_to_run(run_slot, n)) begin
			sel = run_slot;
			found = 1;
		end else if (pol == POL_RR) begin
			// The search starts after the running slot, or at the stale slot when none runs.
			start = run_valid ? int'(run_slot) + 1 : int'(run_slot);
			for (k = 0; k < n && !found; k++) begin
				idx = (start + k) % n;
				if (ready_to_run(idx, n)) begin
					sel = idx;
					found = 1;
				end
			end
			if (found)
				slice_cnt = q;
		end else begin
			for (k = 0; k < n; k++) begin
				if (ready_to_run(k, n)) begin
					case (pol)
						POL_SJF:            key = burst_tbl[k];
						POL_SRTF:           key = left_tbl[k];
						POL_PRIO, POL_PPRIO: key = prio_tbl[k];
						default:            key = arrival_tbl[k];
					endcase
					if (!found || ((pol == POL_PRIO || pol == POL_PPRIO) ? key > best
							: key < best)) begin
						best = key;
						sel = k;
						found = 1;
					end
				end
			end
		end

		if (!found) begin
			run_valid = 0;
			advance_time();
		end else begin
			run_slot = sel;
			run_valid = 1;
			if (left_tbl[sel] != 0)
				left_tbl[sel]--;
			if (pol == POL_RR && slice_cnt != 0)
				slice_cnt--;
			advance_time();
			o.running_valid = 1'b1;
			o.running_slot = sel;
			if (left_tbl[sel] == 0) begin
				done_tbl[sel] = 1'b1;
				run_valid = 0;
				slice_cnt = 0;
				turn = (int'(sched_time) > int'(arrival_tbl[sel])) ?
					int'(sched_time) - int'(arrival_tbl[sel]) : 0;
				wt = (turn > int'(burst_tbl[sel])) ? turn - int'(burst_tbl[sel]) : 0;
				o.finished = 1'b1;
				o.waiting_time = wt;
				o.turnaround_time = turn;
			end
		end
		return o;
	endfunction

	function automatic rsp_t schedule_request(req_t r);
		rsp_t o;
		int   n;
		int   i;
		o = '0;
		case (r.op)
			OP_LOAD: begin
				if (r.slot < SLOTS) begin
					arrival_tbl[r.slot] = r.arrival;
					burst_tbl[r.slot] = r.burst;
					prio_tbl[r.slot] = r.prio;
					left_tbl[r.slot] = r.burst;
					done_tbl[r.slot] = 1'b0;
				end
			end
			OP_TICK: o = run_one_tick();
			OP_RESTART: begin
				for (i = 0; i < SLOTS; i++) begin
					left_tbl[i] = burst_tbl[i];
					done_tbl[i] = 1'b0;
				end
				sched_time = '0;
				run_slot = '0;
				run_valid = 1'b0;
				slice_cnt = '0;
			end
			default: ;
		endcase
		o.now_time = sched_time;
		n = slots_in_use();
		o.all_done = 1'b1;
		for (i = 0; i < n; i++)
			if (!done_tbl[i])
				o.all_done = 1'b0;
		return o;
	endfunction

	function automatic void compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				done_tbl[i] = 1'b0;
			sched_time = '0;
			run_slot = '0;
			run_valid = 1'b0;
			slice_cnt = '0;
			policy_r = POL_FCFS;
			quantum_r = QUANTUM_RST;
			count_r = TASK_COUNT_RST;
			awaited_status.delete();
			predicted <= 0;
			retired <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_POLICY:     policy_r = cfg_wdata[2:0];
					REG_QUANTUM:    quantum_r = cfg_wdata[3:0];
					REG_TASK_COUNT: count_r = cfg_wdata;
					default: ;
				endcase
			end
			// Responses are matched before this edge's request is predicted, so
			// a response cannot be paired with the request taken on the same edge.
			if (rsp_valid && rsp_ready) begin
				if (awaited_status.size() == 0) begin
					$error("response with no request outstanding");
					fails++;
				end else begin
					want = awaited_status.pop_front();
					compare_field("running_valid", want.running_valid, rsp.running_valid);
					compare_field("running_slot", want.running_slot, rsp.running_slot);
					compare_field("now_time", want.now_time, rsp.now_time);
					compare_field("finished", want.finished, rsp.finished);
					compare_field("waiting_time", want.waiting_time, rsp.waiting_time);
					compare_field("turnaround_time", want.turnaround_time,
						rsp.turnaround_time);
					compare_field("all_done", want.all_done, rsp.all_done);
					retired <= retired + 1;
				end
			end
			if (req_valid && req_ready) begin
				awaited_status.push_back(schedule_request(req));
				predicted <= predicted + 1;
			end
		end
	end

endmodule

// File: test/multi_policy_task_scheduler_test.sv
// ----------------------------------------------------------------------------
// multi_policy_task_scheduler_test
// Drives the task scheduler with directed corner requests, then with random
// load, restart and tick sequences under every policy and random register settings,
// with random stalls on both sides, a long output hold-off and a run that
// takes the clock to saturation. The checker beside the block does the
// comparison; this module makes the stimulus and prints the verdict.
// ----------------------------------------------------------------------------
module multi_policy_task_scheduler_test;
	timeunit 1ns;
	timeprecision 1ps;
	import mpts_pkg::*;

	localparam int SLOTS = 16;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 1900;
	localparam int DRAIN_CYCLES = 64;
	localparam int SATURATION_TICKS = 65525;
	localparam int TICK_BUDGET = 90;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam logic [2:0] POL_SPARE_LO = 3'd6;
	localparam logic [2:0] POL_SPARE_HI = 3'd7;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	req_t       req;
	logic       rsp_valid;
	logic       rsp_ready;
	rsp_t       rsp;
	logic       cfg_wr_en;
	logic [1:0] cfg_addr;
	logic [4:0] cfg_wdata;

	int fail_count;
	int pending;
	int send_idle = 0;
	int recv_idle = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int items_sent = 0;
	int cycles = 0;
	int slots_used = SLOTS;

	multi_policy_task_scheduler #(.SLOTS(SLOTS)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	multi_policy_task_scheduler_checker #(.SLOTS(SLOTS)) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Response side: random back-pressure, or a long hold-off when asked for.
	initial begin
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	function automatic req_t with_op(logic [1:0] op);
		req_t r;
		r.op = op;
		r.slot = $urandom;
		r.arrival = $urandom;
		r.burst = $urandom;
		r.prio = $urandom;
		return r;
	endfunction

	task automatic send_request(input req_t r);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle)
			gap++;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic put_reg(input logic [1:0] addr, input logic [4:0] data);
		cfg_wr_en <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Registers change only once every outstanding request has been answered.
	task automatic retune(input logic [3:0] mask, input logic [4:0] pol,
			input logic [4:0] quant, input logic [4:0] count);
		drain();
		if (mask[0])
			put_reg(REG_POLICY, pol);
		if (mask[1])
			put_reg(REG_QUANTUM, quant);
		if (mask[2]) begin
			put_reg(REG_TASK_COUNT, count);
			slots_used = (count > SLOTS) ? SLOTS : int'(count);
		end
		if (mask[3])
			put_reg(REG_SPARE, 5'($urandom));
		cfg_wr_en <= 1'b0;
	endtask

	// One scheduling run: settings, a full task set, usually a restart, then ticks mixed with random requests.
	task automatic run_episode(input logic [2:0] pol_code, input bit squeeze);
		int         n;
		int         k;
		int         offset;
		int         budget;
		int         burst_sum;
		int         arr_max;
		int         arr_v;
		int         burst_v;
		logic [3:0] mask;
		logic [4:0] quant;
		logic [4:0] count;
		req_t       r;
		mask = {($urandom_range(19) == 0), 3'($urandom)} | 4'b0001;
		quant = ($urandom_range(9) == 0) ? {1'($urandom), 4'd0}
			: {1'($urandom), 4'($urandom_range(1, 15))};
		case ($urandom_range(11))
			0:       count = 5'd0;
			1:       count = 5'($urandom_range(17, 31));
			2, 3, 4: count = 5'd16;
			default: count = 5'($urandom_range(1, 8));
		endcase
		retune(mask, {2'($urandom), pol_code}, quant, count);
		n = slots_used;
		offset = $urandom_range(SLOTS - 1);
		burst_sum = 0;
		arr_max = 0;
		for (k = 0; k < n; k++) begin
			arr_v = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(24);
			case ($urandom_range(19))
				0:       burst_v = 0;
				1, 2:    burst_v = $urandom_range(1, 255);
				default: burst_v = $urandom_range(1, 6);
			endcase
			r.op = OP_LOAD;
			r.slot = (offset + k) % n;
			r.arrival = arr_v;
			r.burst = burst_v;
			// Small priorities make ties common.
			r.prio = $urandom_range(1) ? $urandom_range(3) : $urandom_range(255);
			send_request(r);
			burst_sum += burst_v;
			if (arr_v > arr_max)
				arr_max = arr_v;
		end
		if ($urandom_range(9) != 0)
			send_request(with_op(OP_RESTART));
		budget = burst_sum + arr_max + n + 2;
		if (budget > TICK_BUDGET)
			budget = TICK_BUDGET;
		if (squeeze) begin
			if (budget < 40)
				budget = 40;
			hold_req <= hold_req + 1;
		end
		for (k = 0; k < budget; k++) begin
			if ($urandom_range(11) == 0)
				send_request(with_op(2'($urandom)));
			send_request(with_op(OP_TICK));
		end
	endtask

	initial begin
		int   k;
		int   phase;
		int   episode;
		int   goal_end;
		req_t r;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_wr_en <= 1'b0;
		cfg_addr <= REG_POLICY;
		cfg_wdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 19;
		recv_idle <= 74;

		// Fill every slot once, with the field extremes and a zero burst.
		for (k = 0; k < SLOTS; k++) begin
			r.op = OP_LOAD;
			r.slot = k;
			r.arrival = (k == SLOTS - 1) ? 12'hFFF : 12'(k);
			r.burst = (k == 0) ? 8'd0 : (k == SLOTS - 2) ? 8'hFF : 8'(k % 3 + 1);
			r.prio = (k == SLOTS - 1) ? 8'hFF : 8'(k * 17);
			send_request(r);
		end
		r = '1;
		r.op = OP_SPARE;
		send_request(r);
		send_request(with_op(OP_RESTART));
		repeat (3) send_request(with_op(OP_TICK));
		// Unused policy code, quantum zero and no slot in use.
		retune(4'b1111, {2'b11, POL_SPARE_HI}, 5'd0, 5'd0);
		send_request(with_op(OP_TICK));
		// Task count above the table size.
		retune(4'b0101, {2'b00, POL_SPARE_LO}, 5'd0, 5'd31);
		repeat (2) send_request(with_op(OP_TICK));

		episode = 0;
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 19;
					recv_idle <= 74;
				end
				1: begin
					send_idle = 74;
					recv_idle <= 19;
				end
				default: begin
					send_idle = 0;
					recv_idle <= 0;
				end
			endcase
			goal_end = items_sent + RANDOM_ITEMS / 3;
			run_episode(3'(episode % 8), phase != 1);
			episode++;
			while (items_sent < goal_end) begin
				run_episode(3'(episode % 8), 1'b0);
				episode++;
			end
		end

		// Idle ticks with no slot in use walk the clock close to its ceiling, then one round
		// robin task takes it to the ceiling and finishes after the clock has stopped.
		retune(4'b0100, 5'd0, 5'd0, 5'd0);
		send_request(with_op(OP_RESTART));
		repeat (SATURATION_TICKS) send_request(with_op(OP_TICK));
		r.op = OP_LOAD;
		r.slot = 0;
		r.arrival = 12'd4000;
		r.burst = 8'd12;
		r.prio = 8'd1;
		send_request(r);
		retune(4'b0111, {2'b00, POL_RR}, 5'd0, 5'd1);
		repeat (16) send_request(with_op(OP_TICK));
		send_request(with_op(OP_RESTART));

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
